// ----- rtl/gtsw_pkg.sv -----
// gtsw_pkg: shared types and constants of the gamma tuning step weight block
// no dependencies

package gtsw_pkg;

	localparam int unsigned LX_W = 17;
	localparam int unsigned LL_W = 20;
	localparam int unsigned NUM_W = 21;
	localparam int unsigned REG_W = 12;
	localparam int unsigned CFG_W = 20;

	typedef enum logic [2:0] {
		CFG_MODE    = 3'd0,
		CFG_LIMIT_X = 3'd1,
		CFG_LIMIT_Y = 3'd2,
		CFG_LIMIT_L = 3'd3,
		CFG_GMAX    = 3'd4,
		CFG_VMAX    = 3'd5
	} cfg_idx_t;

	localparam logic [LX_W-1:0] LIMIT_X_RST = LX_W'(65);
	localparam logic [LX_W-1:0] LIMIT_Y_RST = LX_W'(65);
	localparam logic [LL_W-1:0] LIMIT_L_RST = LL_W'(256);
	localparam logic [REG_W-1:0] GMAX_RST = REG_W'(511);
	localparam logic [REG_W-1:0] VMAX_RST = REG_W'(2047);

	localparam logic [REG_W:0] GAMMA_MARGIN = 13'd15;
	localparam logic [REG_W:0] VREG_MARGIN = 13'd30;
	localparam logic [REG_W-1:0] GMAX_MIN = 12'd200;
	localparam logic [REG_W-1:0] VMAX_KEEP = 12'd1030;
	localparam logic [REG_W-1:0] VMAX_HALF = 12'd520;
	localparam logic [7:0] LOOP_LIMIT = 8'd30;
	localparam logic [LL_W-1:0] HIGH_LV = 20'd128000;

	// floor(q / 5) == (q * RECIP5) >> RECIP5_SH for q below 2^22
	localparam logic [19:0] RECIP5 = 20'd838861;
	localparam int unsigned RECIP5_SH = 22;

	typedef struct packed {
		logic mode;
		logic near;
		logic xy_edge;
		logic lv_edge;
		logic sub_edge;
		logic high;
		logic vkeep;
		logic vhalf;
	} side_t;

endpackage

// ----- rtl/gamma_tuning_step_weight.sv -----
// gamma_tuning_step_weight: top level, step weights from colour error
// depends on gtsw_pkg and gtsw_div
//
// Fully pipelined: one word enters per cycle while the output is not stalled.
// The pipeline is made of the three 21-stage dividers that count error
// limits, one quotient bit per stage, plus an input stage, a reciprocal
// multiply stage for the divide by five and an output stage. A stall on the
// output holds the whole pipeline and is passed straight back to the input.

module gamma_tuning_step_weight #(
	parameter int unsigned WEIGHT_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [19:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [17:0]      diff_x,
	input  logic signed [17:0]      diff_y,
	input  logic signed [20:0]      diff_lv,
	input  logic [19:0]             target_lv,
	input  logic [11:0]             gamma_red,
	input  logic [11:0]             gamma_green,
	input  logic [11:0]             gamma_blue,
	input  logic [11:0]             vreg1_value,
	input  logic [7:0]              loop_number,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [WEIGHT_BITS-1:0]  xy_step_weight,
	output logic [WEIGHT_BITS-1:0]  lv_step_weight
);

	localparam int unsigned NW = gtsw_pkg::NUM_W;
	localparam int unsigned PW = NW + 20;
	localparam logic [NW-1:0] WMAX = NW'((1 << WEIGHT_BITS) - 1);

	logic                         mode_q;
	logic [gtsw_pkg::LX_W-1:0]    limx_q, limy_q;
	logic [gtsw_pkg::LL_W-1:0]    liml_q;
	logic [gtsw_pkg::REG_W-1:0]   gmax_q, vmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			limx_q <= gtsw_pkg::LIMIT_X_RST;
			limy_q <= gtsw_pkg::LIMIT_Y_RST;
			liml_q <= gtsw_pkg::LIMIT_L_RST;
			gmax_q <= gtsw_pkg::GMAX_RST;
			vmax_q <= gtsw_pkg::VMAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gtsw_pkg::CFG_MODE:    mode_q <= cfg_data[0];
				gtsw_pkg::CFG_LIMIT_X: limx_q <= cfg_data[16:0];
				gtsw_pkg::CFG_LIMIT_Y: limy_q <= cfg_data[16:0];
				gtsw_pkg::CFG_LIMIT_L: liml_q <= cfg_data;
				gtsw_pkg::CFG_GMAX:    gmax_q <= cfg_data[11:0];
				gtsw_pkg::CFG_VMAX:    vmax_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: magnitudes and edge tests
	logic [17:0] ax, ay;
	logic [20:0] al;
	gtsw_pkg::side_t side;
	logic [12:0] gmax_e, vmax_e;
	logic rb_edge;

	assign ax = diff_x[17] ? 18'(-diff_x) : diff_x;
	assign ay = diff_y[17] ? 18'(-diff_y) : diff_y;
	assign al = diff_lv[20] ? 21'(-diff_lv) : diff_lv;
	assign gmax_e = {1'b0, gmax_q};
	assign vmax_e = {1'b0, vmax_q};

	always_comb begin
		rb_edge = ({1'b0, gamma_red} + gtsw_pkg::GAMMA_MARGIN > gmax_e)
			|| ({1'b0, gamma_blue} + gtsw_pkg::GAMMA_MARGIN > gmax_e)
			|| ({1'b0, gamma_red} < gtsw_pkg::GAMMA_MARGIN)
			|| ({1'b0, gamma_blue} < gtsw_pkg::GAMMA_MARGIN);
		side.mode = mode_q;
		side.near = ({1'b0, al} < {1'b0, liml_q, 1'b0})
			&& ({1'b0, ax} < {1'b0, limx_q, 1'b0})
			&& ({1'b0, ay} < {1'b0, limy_q, 1'b0});
		side.xy_edge = rb_edge || (loop_number > gtsw_pkg::LOOP_LIMIT);
		side.lv_edge = ({1'b0, vreg1_value} + gtsw_pkg::VREG_MARGIN > vmax_e)
			|| ({1'b0, vreg1_value} < gtsw_pkg::VREG_MARGIN)
			|| (loop_number > gtsw_pkg::LOOP_LIMIT);
		side.sub_edge = rb_edge
			|| ({1'b0, gamma_green} + gtsw_pkg::GAMMA_MARGIN > gmax_e)
			|| ({1'b0, gamma_green} < gtsw_pkg::GAMMA_MARGIN)
			|| (gmax_q < gtsw_pkg::GMAX_MIN);
		side.high = target_lv > gtsw_pkg::HIGH_LV;
		side.vkeep = vmax_q > gtsw_pkg::VMAX_KEEP;
		side.vhalf = (vmax_q > gtsw_pkg::VMAX_HALF) && !side.vkeep;
	end

	logic [17:0] ax_s1, ay_s1;
	logic [20:0] al_s1;
	gtsw_pkg::side_t side_s1;
	logic vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax;
			ay_s1 <= ay;
			al_s1 <= al;
			side_s1 <= side;
		end
	end

	// stages 2 to 22: limit counts
	logic [NW-1:0] qx, qy, ql;

	gtsw_div #(.NW(NW), .DW(gtsw_pkg::LX_W)) u_div_x (
		.clk(clk), .en(en), .num(NW'(ax_s1)), .den(limx_q), .quo(qx));
	gtsw_div #(.NW(NW), .DW(gtsw_pkg::LX_W)) u_div_y (
		.clk(clk), .en(en), .num(NW'(ay_s1)), .den(limy_q), .quo(qy));
	gtsw_div #(.NW(NW), .DW(gtsw_pkg::LL_W)) u_div_l (
		.clk(clk), .en(en), .num(al_s1), .den(liml_q), .quo(ql));

	gtsw_pkg::side_t side_d [NW];
	logic            vld_d  [NW];

	for (genvar i = 0; i < NW; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[i] <= 1'b0;
			else if (en) vld_d[i] <= (i == 0) ? vld_s1 : vld_d[(i == 0) ? 0 : i-1];
		end
		always_ff @(posedge clk) begin
			if (en) side_d[i] <= (i == 0) ? side_s1 : side_d[(i == 0) ? 0 : i-1];
		end
	end

	// stage 23: divide by five
	logic [NW-1:0] qmin;
	logic [PW-1:0] pxy, plv;
	logic [NW-1:0] xy5_s23, lv5_s23, ql_s23;
	gtsw_pkg::side_t side_s23;
	logic vld_s23;

	assign qmin = (qx < qy) ? qx : qy;
	assign pxy = PW'(qmin) * PW'(gtsw_pkg::RECIP5);
	assign plv = PW'(ql) * PW'(gtsw_pkg::RECIP5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s23 <= 1'b0;
		else if (en) vld_s23 <= vld_d[NW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xy5_s23 <= pxy[gtsw_pkg::RECIP5_SH +: NW];
			lv5_s23 <= plv[gtsw_pkg::RECIP5_SH +: NW];
			ql_s23 <= ql;
			side_s23 <= side_d[NW-1];
		end
	end

	// stage 24: rule selection and output register
	logic [NW-1:0] xyw, lvw;

	always_comb begin
		xyw = xy5_s23;
		if (side_s23.mode) begin
			lvw = side_s23.vhalf ? (ql_s23 >> 1) : ql_s23;
			if (side_s23.near) begin
				xyw = NW'(1);
				lvw = NW'(1);
			end
			if (side_s23.xy_edge) xyw = NW'(1);
			if (side_s23.lv_edge) lvw = NW'(1);
			if (xyw == '0) xyw = NW'(1);
			if (lvw == '0) lvw = NW'(1);
		end else begin
			lvw = lv5_s23;
			if (side_s23.sub_edge || side_s23.near) begin
				xyw = NW'(1);
				lvw = NW'(1);
			end
			if (xyw == '0) xyw = NW'(1);
			if (lvw == '0) lvw = NW'(1);
			if (side_s23.high) begin
				if (xyw > NW'(3)) xyw = NW'(3);
				if (lvw > NW'(3)) lvw = NW'(3);
			end
		end
		if (xyw > WMAX) xyw = WMAX;
		if (lvw > WMAX) lvw = WMAX;
	end

	logic vld_s24;
	logic [WEIGHT_BITS-1:0] xy_s24, lv_s24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s24 <= 1'b0;
		else if (en) vld_s24 <= vld_s23;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xy_s24 <= xyw[WEIGHT_BITS-1:0];
			lv_s24 <= lvw[WEIGHT_BITS-1:0];
		end
	end

	assign out_valid = vld_s24;
	assign xy_step_weight = xy_s24;
	assign lv_step_weight = lv_s24;

	a_xy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> xy_step_weight != '0) else $error("xy weight zero");
	a_lv_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lv_step_weight != '0) else $error("lv weight zero");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("input stalled without cause");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && vld_s23 |=> out_valid) else $error("word lost at output");

endmodule

// ----- rtl/gtsw_div.sv -----
// gtsw_div: pipelined restoring divider, one quotient bit per register stage
// depends on nothing; a zero divisor gives an all-ones quotient

module gtsw_div #(
	parameter int unsigned NW = 21,
	parameter int unsigned DW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] den_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [NW-1:0] num_in;
		logic [NW-1:0] quo_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   trial;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign num_in = num_s[i-1];
			assign quo_in = quo_s[i-1];
			assign den_in = den_s[i-1];
		end

		assign trial = {rem_in, num_in[NW-1]};
		assign take = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
				num_s[i] <= {num_in[NW-2:0], 1'b0};
				quo_s[i] <= {quo_in[NW-2:0], take};
				den_s[i] <= den_in;
			end
		end
	end

	assign quo = quo_s[NW-1];

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking testbench of gamma_tuning_step_weight, directed and random words
// depends on gtsw_pkg and the gamma_tuning_step_weight rtl

module tb_top;

	typedef struct {
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [20:0] dl;
		logic [19:0] tl;
		logic [11:0] gr;
		logic [11:0] gg;
		logic [11:0] gb;
		logic [11:0] v1;
		logic [7:0] lp;
	} meas_t;

	typedef struct {
		logic [7:0] xy;
		logic [7:0] lv;
	} weights_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [17:0] diff_x, diff_y;
	logic signed [20:0] diff_lv;
	logic [19:0] target_lv;
	logic [11:0] gamma_red, gamma_green, gamma_blue, vreg1_value;
	logic [7:0] loop_number;
	logic [7:0] xy_step_weight, lv_step_weight;

	meas_t pend_q[$];
	weights_t weight_q[$];
	int in_idle_pct, out_idle_pct;
	bit failed = 1'b0;
	int quiet_cycles = 0;

	logic mode_sh;
	longint lim_x_sh, lim_y_sh, lim_l_sh, gmax_sh, vmax_sh;

	gamma_tuning_step_weight dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic weights_t step_weights(meas_t m);
		longint ax, ay, al, qx, qy, ql, xy, lv;
		longint gr, gg, gb, v1, lp;
		bit near;
		weights_t w;
		ax = mag(longint'(m.dx));
		ay = mag(longint'(m.dy));
		al = mag(longint'(m.dl));
		gr = m.gr;
		gg = m.gg;
		gb = m.gb;
		v1 = m.v1;
		lp = m.lp;
		qx = lim_x_sh == 0 ? 64'hFFFFFFFF : ax / lim_x_sh;
		qy = lim_y_sh == 0 ? 64'hFFFFFFFF : ay / lim_y_sh;
		ql = lim_l_sh == 0 ? 64'hFFFFFFFF : al / lim_l_sh;
		xy = (qx < qy ? qx : qy) / 5;
		near = al < 2 * lim_l_sh && ax < 2 * lim_x_sh && ay < 2 * lim_y_sh;
		if (mode_sh) begin
			lv = ql;
			if (vmax_sh <= 1030 && vmax_sh > 520)
				lv = lv >> 1;
			if (near) begin
				xy = 1;
				lv = 1;
			end
			if (gr > gmax_sh - 15 || gb > gmax_sh - 15 || gr < 15 || gb < 15 || lp > 30)
				xy = 1;
			if (xy < 1)
				xy = 1;
			if (v1 > vmax_sh - 30 || v1 < 30 || lp > 30)
				lv = 1;
			if (lv < 1)
				lv = 1;
		end else begin
			lv = ql / 5;
			if (gr > gmax_sh - 15 || gg > gmax_sh - 15 || gb > gmax_sh - 15 ||
			    gr < 15 || gg < 15 || gb < 15 || gmax_sh < 200 || near) begin
				xy = 1;
				lv = 1;
			end
			if (xy < 1)
				xy = 1;
			if (lv < 1)
				lv = 1;
			if (m.tl > 128000) begin
				if (xy > 3)
					xy = 3;
				if (lv > 3)
					lv = 3;
			end
		end
		w.xy = xy > 255 ? 8'd255 : xy[7:0];
		w.lv = lv > 255 ? 8'd255 : lv[7:0];
		return w;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		meas_t m;
		if (!arst_n) begin
			in_valid <= 0;
			diff_x <= 0; diff_y <= 0; diff_lv <= 0; target_lv <= 0;
			gamma_red <= 0; gamma_green <= 0; gamma_blue <= 0;
			vreg1_value <= 0; loop_number <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				m.dx = diff_x; m.dy = diff_y; m.dl = diff_lv; m.tl = target_lv;
				m.gr = gamma_red; m.gg = gamma_green; m.gb = gamma_blue;
				m.v1 = vreg1_value; m.lp = loop_number;
				weight_q.push_back(step_weights(m));
			end
			if (!in_valid || !in_stall) begin
				if (pend_q.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
					m = pend_q.pop_front();
					diff_x <= m.dx; diff_y <= m.dy; diff_lv <= m.dl; target_lv <= m.tl;
					gamma_red <= m.gr; gamma_green <= m.gg; gamma_blue <= m.gb;
					vreg1_value <= m.v1; loop_number <= m.lp;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		weights_t w;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (weight_q.size() == 0) begin
					$display("%0t: word with none expected, xy %0d lv %0d", $time,
						xy_step_weight, lv_step_weight);
					failed = 1;
				end else begin
					w = weight_q.pop_front();
					if (xy_step_weight !== w.xy) begin
						$display("%0t: xy_step_weight expected %0d actual %0d", $time,
							w.xy, xy_step_weight);
						failed = 1;
					end
					if (lv_step_weight !== w.lv) begin
						$display("%0t: lv_step_weight expected %0d actual %0d", $time,
							w.lv, lv_step_weight);
						failed = 1;
					end
				end
			end
			out_stall <= $urandom_range(0, 99) < out_idle_pct;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("gamma_tuning_step_weight: mismatch");
			$finish;
		end
	end

	task automatic drain();
		while (pend_q.size() > 0 || in_valid || weight_q.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(gtsw_pkg::cfg_idx_t idx, longint val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[19:0];
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			gtsw_pkg::CFG_MODE:    mode_sh = val[0];
			gtsw_pkg::CFG_LIMIT_X: lim_x_sh = val[16:0];
			gtsw_pkg::CFG_LIMIT_Y: lim_y_sh = val[16:0];
			gtsw_pkg::CFG_LIMIT_L: lim_l_sh = val[19:0];
			gtsw_pkg::CFG_GMAX:    gmax_sh = val[11:0];
			gtsw_pkg::CFG_VMAX:    vmax_sh = val[11:0];
			default: ;
		endcase
	endtask

	task automatic setup(logic md, longint lx, longint ly, longint ll, longint gm, longint vm);
		drain();
		write_reg(gtsw_pkg::CFG_MODE, md);
		write_reg(gtsw_pkg::CFG_LIMIT_X, lx);
		write_reg(gtsw_pkg::CFG_LIMIT_Y, ly);
		write_reg(gtsw_pkg::CFG_LIMIT_L, ll);
		write_reg(gtsw_pkg::CFG_GMAX, gm);
		write_reg(gtsw_pkg::CFG_VMAX, vm);
	endtask

	task automatic add(longint dx, longint dy, longint dl, longint tl, longint gr, longint gg,
		longint gb, longint v1, longint lp);
		meas_t m;
		m.dx = dx; m.dy = dy; m.dl = dl; m.tl = tl;
		m.gr = gr; m.gg = gg; m.gb = gb; m.v1 = v1; m.lp = lp;
		pend_q.push_back(m);
	endtask

	// error of under 401 limits of either sign, redrawn within the field range when too large
	function automatic longint near_err(longint lim, longint top);
		longint k, v;
		k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 400);
		v = lim * k + $urandom_range(0, lim > 1 ? lim - 1 : 0);
		if (v > top)
			v = $urandom_range(0, top);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic longint reg_val(longint top, longint margin);
		if ($urandom_range(0, 4) == 0 || top < 2 * margin + 2)
			return $urandom_range(0, 4095);
		return $urandom_range(margin, top - margin);
	endfunction

	task automatic add_random(int n);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				add($urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
					$urandom_range(0, 2097151) - 1048576, $urandom_range(0, 1048575),
					$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 255));
			else
				add(near_err(lim_x_sh, 131071), near_err(lim_y_sh, 131071),
					near_err(lim_l_sh, 1048575),
					$urandom_range(0, 1) ? $urandom_range(0, 128000) : $urandom_range(127990, 1048575),
					reg_val(gmax_sh, 15), reg_val(gmax_sh, 15), reg_val(gmax_sh, 15),
					reg_val(vmax_sh, 30), $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
					: $urandom_range(0, 31));
		end
	endtask

	initial begin
		in_idle_pct = 18;
		out_idle_pct = 54;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		mode_sh = 0; lim_x_sh = 65; lim_y_sh = 65; lim_l_sh = 256;
		gmax_sh = 511; vmax_sh = 2047;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// sub rule at reset values
		add(-131072, -131072, -1048576, 0, 200, 200, 200, 1000, 0);
		add(131071, 131071, 1048575, 1048575, 200, 200, 200, 1000, 0);
		add(131071, 131071, 1048575, 128000, 200, 200, 200, 1000, 0);
		add(131071, 131071, 1048575, 128001, 200, 200, 200, 1000, 0);
		add(0, 0, 0, 0, 200, 200, 200, 1000, 0);
		add(129, -129, 511, 0, 200, 200, 200, 1000, 0);
		add(130, 130, 512, 0, 200, 200, 200, 1000, 0);
		add(5000, 5000, 50000, 0, 0, 200, 200, 1000, 0);
		add(5000, 5000, 50000, 0, 200, 4095, 200, 1000, 0);
		add(5000, 5000, 50000, 0, 200, 200, 496, 1000, 255);
		add(5000, 5000, 50000, 0, 497, 15, 14, 1000, 0);
		add(5000, 100, 50000, 0, 300, 300, 300, 1000, 0);
		add_random(60);

		setup(1, 65, 65, 256, 511, 2047);
		add(5000, 5000, 50000, 0, 200, 4095, 200, 1000, 30);
		add(5000, 5000, 50000, 0, 200, 0, 200, 1000, 31);
		add(5000, 5000, 50000, 0, 14, 200, 200, 1000, 0);
		add(5000, 5000, 50000, 0, 200, 200, 200, 29, 0);
		add(5000, 5000, 50000, 0, 200, 200, 200, 2018, 0);
		add(5000, 5000, 50000, 0, 200, 200, 200, 2017, 0);
		add(100, 100, 100, 0, 200, 200, 200, 1000, 0);
		add(100, 100, 100, 0, 0, 200, 0, 0, 0);
		add_random(60);
		drain();
		add_random(10);

		setup(1, 1, 1, 1, 4095, 800);
		add_random(70);

		in_idle_pct = 54;
		out_idle_pct = 18;
		setup(1, 131071, 131071, 1048575, 20, 1030);
		add_random(60);
		setup(1, 300, 90, 4000, 4095, 0);
		add_random(40);

		in_idle_pct = 0;
		out_idle_pct = 0;
		setup(0, 131071, 131071, 1048575, 199, 521);
		add_random(40);
		setup(0, 3, 7, 40, 4095, 4095);
		add_random(70);
		setup(0, $urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(1, 9000),
			$urandom_range(200, 4095), $urandom_range(0, 4095));
		add_random(50);

		drain();
		if (!failed)
			$display("gamma_tuning_step_weight: match");
		else
			$display("gamma_tuning_step_weight: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/gtsw_pkg.sv
rtl/gtsw_div.sv
rtl/gamma_tuning_step_weight.sv
tb/tb_top.sv
